FILE: hdl/salwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salwc_pkg: shared types and constants for the LRU write-back cache
// Command codes, field widths and the controller/datapath command struct.
// ----------------------------------------------------------------------------
package salwc_pkg;

  localparam int unsigned CmdW  = 2;
  localparam int unsigned AddrW = 16;
  localparam int unsigned DataW = 16;

  localparam logic [CmdW-1:0] CMD_READ  = 2'd0;
  localparam logic [CmdW-1:0] CMD_WRITE = 2'd1;
  localparam logic [CmdW-1:0] CMD_LOAD  = 2'd2;

  localparam logic [7:0] BYTE_MASK = 8'hFF;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;    // latch the incoming item
    logic lookup;     // register tag compare and victim choice
    logic mem_rd;     // start read of memory word (refill or load merge)
    logic mem_wb;     // write victim line back to memory
    logic mem_ld;     // direct memory load
    logic fill;       // install refilled line
    logic update;     // read/merge, touch ages, build result
    logic clr_res;    // result of load or unused command
  } salwc_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            hit;
    logic            victim_dirty;
  } salwc_sts_t;

  // merge write data into an old word
  function automatic logic [DataW-1:0] merge_word(input logic [DataW-1:0] old_w,
                                                  input logic [DataW-1:0] data,
                                                  input logic             word,
                                                  input logic             high);
    logic [DataW-1:0] r;
    if (word) begin
      r = data;
    end else if (high) begin
      r = {data[7:0] & BYTE_MASK, old_w[7:0]};
    end else begin
      r = {old_w[15:8], data[7:0] & BYTE_MASK};
    end
    return r;
  endfunction

endpackage

FILE: hdl/salwc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salwc_ctrl: sequencing state machine
// Steps one item through lookup, write-back, refill and update, or a direct load.
// ----------------------------------------------------------------------------
module salwc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  res_load_o,
  input  logic                  res_free_i,
  input  salwc_pkg::salwc_sts_t sts_i,
  output salwc_pkg::salwc_cmd_t cmd_o
);
  import salwc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_WB, S_RD, S_FILL, S_UPD, S_LD
  } state_e;

  state_e state_q;
  logic   looked_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o         = '0;
    res_load_o    = 1'b0;
    cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
    unique case (state_q)
      S_IDLE: ;
      S_LOOK: begin
        if (sts_i.cmd == CMD_LOAD) begin
          // fetch the old word for a byte merge
          cmd_o.mem_rd = 1'b1;
        end else if (sts_i.cmd != CMD_READ && sts_i.cmd != CMD_WRITE) begin
          if (res_free_i) begin
            cmd_o.clr_res = 1'b1;
            res_load_o    = 1'b1;
          end
        end else begin
          cmd_o.lookup = 1'b1;
        end
      end
      S_LD: begin
        if (res_free_i) begin
          cmd_o.mem_ld  = 1'b1;
          cmd_o.clr_res = 1'b1;
          res_load_o    = 1'b1;
        end
      end
      S_WB:   cmd_o.mem_wb = 1'b1;
      S_RD:   cmd_o.mem_rd = 1'b1;
      S_FILL: cmd_o.fill   = 1'b1;
      S_UPD: begin
        // a fresh miss goes to refill first
        if (!(looked_q && !sts_i.hit) && res_free_i) begin
          cmd_o.update = 1'b1;
          res_load_o   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // state register; lookup result is registered and seen in S_UPD
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      looked_q <= 1'b0;
    end else begin
      looked_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_LOOK;
        S_LOOK: begin
          if (sts_i.cmd == CMD_READ || sts_i.cmd == CMD_WRITE) begin
            state_q  <= S_UPD;
            looked_q <= 1'b1;
          end else if (sts_i.cmd == CMD_LOAD) begin
            state_q <= S_LD;
          end else if (res_free_i) begin
            state_q <= S_IDLE;
          end
        end
        S_LD:   if (res_free_i) state_q <= S_IDLE;
        S_WB:   state_q <= S_RD;
        S_RD:   state_q <= S_FILL;
        S_FILL: state_q <= S_UPD;
        S_UPD: begin
          if (looked_q && !sts_i.hit) begin
            state_q <= sts_i.victim_dirty ? S_WB : S_RD;
          end else if (res_free_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE) else $error("ready outside idle");
  a_wb_then_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WB |=> state_q == S_RD) else $error("write-back not followed by refill");
  a_fill_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILL |=> state_q == S_UPD) else $error("fill not followed by update");
`endif
endmodule

FILE: hdl/salwc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salwc_dp: cache datapath
// Line arrays, LRU ages, tag compare, backing memory and result register.
// ----------------------------------------------------------------------------
module salwc_dp #(
  parameter int unsigned SETS      = 4,
  parameter int unsigned WAYS      = 4,
  parameter int unsigned MEM_WORDS = 32768
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [salwc_pkg::CmdW-1:0]        command_i,
  input  logic                              word_access_i,
  input  logic [salwc_pkg::AddrW-1:0]       address_i,
  input  logic [salwc_pkg::DataW-1:0]       write_data_i,
  input  salwc_pkg::salwc_cmd_t             cmd_i,
  output salwc_pkg::salwc_sts_t             sts_o,
  output logic [salwc_pkg::DataW-1:0]       read_data_o,
  output logic                              hit_o,
  output logic                              wrote_back_o
);
  import salwc_pkg::*;

  localparam int unsigned NLines = SETS * WAYS;
  localparam int unsigned SetW   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WayW   = $clog2(WAYS);
  localparam int unsigned LineW  = (NLines > 1) ? $clog2(NLines) : 1;
  localparam int unsigned MemW   = $clog2(MEM_WORDS);
  localparam int unsigned WaddrW = AddrW - 1;

  // latched item
  logic [CmdW-1:0]   cmd_q;
  logic              word_q;
  logic              high_q;
  logic [WaddrW-1:0] waddr_q;
  logic [DataW-1:0]  wdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= command_i;
      word_q  <= word_access_i;
      high_q  <= address_i[0];
      waddr_q <= address_i[AddrW-1:1];
      wdata_q <= write_data_i;
    end
  end

  logic [SetW-1:0] set_idx;
  if (SETS > 1) begin : g_set
    assign set_idx = waddr_q[SetW-1:0];
  end else begin : g_noset
    assign set_idx = '0;
  end

  // line storage
  logic              valid_q [NLines];
  logic              dirty_q [NLines];
  logic [WayW-1:0]   age_q   [NLines];
  logic [WaddrW-1:0] tag_q   [NLines];
  logic [DataW-1:0]  data_q  [NLines];

  function automatic logic [LineW-1:0] lidx(input logic [SetW-1:0] s,
                                           input logic [WayW-1:0] w);
    logic [31:0] t;
    t = 32'(s) * 32'(WAYS) + 32'(w);
    return t[LineW-1:0];
  endfunction

  // tag compare and victim search over one set
  logic            hit_c;
  logic [WayW-1:0] hway_c, vway_c;
  logic            vfound_c;
  always_comb begin
    hit_c    = 1'b0;
    hway_c   = '0;
    vfound_c = 1'b0;
    vway_c   = WayW'(WAYS - 1);
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_c && valid_q[lidx(set_idx, WayW'(w))] &&
          tag_q[lidx(set_idx, WayW'(w))] == waddr_q) begin
        hit_c  = 1'b1;
        hway_c = WayW'(w);
      end
      if (!vfound_c && age_q[lidx(set_idx, WayW'(w))] == WayW'(WAYS - 1)) begin
        vfound_c = 1'b1;
        vway_c   = WayW'(w);
      end
    end
  end

  logic            hit_q;
  logic [WayW-1:0] way_q;
  logic            vdirty_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q    <= 1'b0;
      vdirty_q <= 1'b0;
    end else if (cmd_i.lookup) begin
      hit_q    <= hit_c;
      vdirty_q <= !hit_c && valid_q[lidx(set_idx, vway_c)] && dirty_q[lidx(set_idx, vway_c)];
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) way_q <= hit_c ? hway_c : vway_c;
  end

  assign sts_o.cmd          = cmd_q;
  assign sts_o.hit          = hit_q;
  assign sts_o.victim_dirty = vdirty_q;

  logic [LineW-1:0] cur;
  assign cur = lidx(set_idx, way_q);

  // backing memory, one port
  logic [DataW-1:0] mem [MEM_WORDS];
  logic [DataW-1:0] mem_rd_q;
  logic [MemW-1:0]  m_addr;
  logic [MemW-1:0]  wb_addr;
  assign m_addr  = waddr_q[MemW-1:0];
  assign wb_addr = tag_q[cur][MemW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wb) begin
      mem[wb_addr] <= data_q[cur];
    end else if (cmd_i.mem_ld) begin
      mem[m_addr] <= merge_word(mem_rd_q, wdata_q, word_q, high_q);
    end
    if (cmd_i.mem_rd) mem_rd_q <= mem[m_addr];
  end

  // a load reads the old word in the lookup state and merges into it in S_LD,
  // which can wait for the result register; mem_rd_q holds until the merge is written

  logic [DataW-1:0] v;
  assign v = data_q[cur];

  logic [WayW-1:0] cur_age;
  assign cur_age = age_q[cur];

  // line state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NLines; i++) begin
        valid_q[i] <= 1'b0;
        dirty_q[i] <= 1'b0;
        age_q[i]   <= WayW'(i % WAYS);
      end
    end else if (cmd_i.fill) begin
      valid_q[cur] <= 1'b1;
      dirty_q[cur] <= 1'b0;
    end else if (cmd_i.update) begin
      if (cmd_q == CMD_WRITE) dirty_q[cur] <= 1'b1;
      for (int w = 0; w < WAYS; w++) begin
        if (age_q[lidx(set_idx, WayW'(w))] < cur_age)
          age_q[lidx(set_idx, WayW'(w))] <= age_q[lidx(set_idx, WayW'(w))] + 1'b1;
      end
      age_q[cur] <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill) begin
      tag_q[cur]  <= waddr_q;
      data_q[cur] <= mem_rd_q;
    end else if (cmd_i.update && cmd_q == CMD_WRITE) begin
      data_q[cur] <= merge_word(v, wdata_q, word_q, high_q);
    end
  end

  // wrote-back flag for this item
  logic wb_seen_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wb_seen_q <= 1'b0;
    else if (cmd_i.capture) wb_seen_q <= 1'b0;
    else if (cmd_i.mem_wb) wb_seen_q <= 1'b1;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_res) begin
      read_data_o  <= '0;
      hit_o        <= 1'b0;
      wrote_back_o <= 1'b0;
    end else if (cmd_i.update) begin
      hit_o        <= hit_q;
      wrote_back_o <= wb_seen_q;
      if (cmd_q == CMD_READ) begin
        read_data_o <= word_q ? v : (high_q ? {8'h00, v[15:8]} : {8'h00, v[7:0]});
      end else begin
        read_data_o <= '0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_after_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill |-> !hit_q) else $error("fill on a hit");
  a_wb_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mem_wb |-> vdirty_q) else $error("write-back of clean line");
  a_one_mem_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_i.mem_wb, cmd_i.mem_ld, cmd_i.fill}) <= 1) else $error("memory port clash");
`endif
endmodule

FILE: hdl/set_assoc_lru_writeback_cache_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_unit: set-associative LRU write-back cache
// Stream front end around the cache controller and datapath.
// ----------------------------------------------------------------------------
// Misses refill on the memory port; a dirty miss first writes the victim
// back, then refills. Unused commands, loads and hits need no refill.
// One item at a time; the result register frees once the item is taken.
// Reset: valid and dirty bits cleared, ages set to way number; memory and
// line data are not cleared.
module set_assoc_lru_writeback_cache_unit #(
  parameter int unsigned SETS      = 4,
  parameter int unsigned WAYS      = 4,
  parameter int unsigned MEM_WORDS = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] command, [2] word_access, [18:3] address, [34:19] write_data
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] read_data, [16] hit, [17] wrote_back
  output logic [23:0] m_axis_tdata
);
  import salwc_pkg::*;

  salwc_cmd_t cmd;
  salwc_sts_t sts;
  logic       res_load;
  logic       out_valid_q;
  logic [DataW-1:0] rdata;
  logic       hit, wb;

  salwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .res_load_o (res_load),
    .res_free_i (!out_valid_q || m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  salwc_dp #(.SETS(SETS), .WAYS(WAYS), .MEM_WORDS(MEM_WORDS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .command_i     (s_axis_tdata[1:0]),
    .word_access_i (s_axis_tdata[2]),
    .address_i     (s_axis_tdata[18:3]),
    .write_data_i  (s_axis_tdata[34:19]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .read_data_o   (rdata),
    .hit_o         (hit),
    .wrote_back_o  (wb)
  );

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (res_load) out_valid_q <= 1'b1;
    else if (m_axis_tready) out_valid_q <= 1'b0;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, wb, hit, rdata};

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("result changed");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> !out_valid_q || m_axis_tready) else $error("result overwritten");
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("second item taken");
`endif
endmodule

FILE: dv/set_assoc_lru_writeback_cache_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_unit_test: self-checking cache testbench
// Drives cache accesses, direct memory loads and unused commands over the input stream,
// predicts each result with a behavioural cache and memory model held in a
// scoreboard, and compares every returned item under varied idling and stalls.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache_unit_test;
  import salwc_pkg::*;

  localparam int NSETS = 4;
  localparam int NWAYS = 4;
  localparam int NMEM  = 32768;

  typedef struct packed {
    logic [15:0] rd;
    logic        hit;
    logic        wb;
  } cache_res_t;

  // behavioural cache plus queue of pending results
  class cache_scoreboard;
    bit          vld[NSETS*NWAYS];
    bit          dty[NSETS*NWAYS];
    logic [14:0] tag[NSETS*NWAYS];
    logic [15:0] dat[NSETS*NWAYS];
    logic [1:0]  age[NSETS*NWAYS];
    logic [15:0] mem[int];
    cache_res_t  pending[$];
    int          errors;

    function new();
      for (int i = 0; i < NSETS*NWAYS; i++) begin
        vld[i] = 0; dty[i] = 0; age[i] = 2'(i % NWAYS);
      end
      errors = 0;
    endfunction

    function logic [15:0] merge(logic [15:0] o, logic [15:0] d, bit wd, bit hi);
      if (wd) return d;
      if (hi) return {d[7:0], o[7:0]};
      return {o[15:8], d[7:0]};
    endfunction

    // predict the result of one accepted item
    function void note_item(logic [1:0] cmd, bit wd, logic [15:0] addr,
                            logic [15:0] d);
      cache_res_t  r;
      logic [14:0] wa;
      int          base, way, mi;
      logic [15:0] v;
      logic [1:0]  a;
      r = '0;
      wa = addr[15:1];
      mi = wa % NMEM;
      base = (wa % NSETS) * NWAYS;
      way = -1;
      if (cmd == CMD_LOAD) begin
        mem[mi] = merge(mem.exists(mi) ? mem[mi] : 16'h0, d, wd, addr[0]);
      end else if (cmd == CMD_READ || cmd == CMD_WRITE) begin
        for (int w = 0; w < NWAYS; w++)
          if (way < 0 && vld[base+w] && tag[base+w] == wa) way = w;
        if (way >= 0) begin
          r.hit = 1;
        end else begin
          way = NWAYS - 1;
          for (int w = NWAYS - 1; w >= 0; w--)
            if (age[base+w] == NWAYS - 1) way = w;
          if (vld[base+way] && dty[base+way]) begin
            mem[tag[base+way] % NMEM] = dat[base+way];
            r.wb = 1;
          end
          vld[base+way] = 1; dty[base+way] = 0; tag[base+way] = wa;
          dat[base+way] = mem.exists(mi) ? mem[mi] : 16'h0;
        end
        v = dat[base+way];
        if (cmd == CMD_READ) begin
          r.rd = wd ? v : (addr[0] ? {8'h0, v[15:8]} : {8'h0, v[7:0]});
        end else begin
          dat[base+way] = merge(v, d, wd, addr[0]);
          dty[base+way] = 1;
        end
        a = age[base+way];
        for (int w = 0; w < NWAYS; w++)
          if (age[base+w] < a) age[base+w]++;
        age[base+way] = 0;
      end
      pending.push_back(r);
    endfunction

    task check_result(logic [23:0] t);
      cache_res_t e;
      if (pending.size() == 0) begin
        report("result with nothing pending", t, 24'h0);
        return;
      end
      e = pending.pop_front();
      if (t[15:0] !== e.rd) report("read_data", {8'h0, t[15:0]}, {8'h0, e.rd});
      if (t[16] !== e.hit) report("hit", {23'h0, t[16]}, {23'h0, e.hit});
      if (t[17] !== e.wb) report("wrote_back", {23'h0, t[17]}, {23'h0, e.wb});
    endtask

    task report(string what, logic [23:0] got, logic [23:0] exp);
      $display("error: %s got %h want %h at %0t", what, got, exp, $time);
      errors++;
    endtask

    // word is safe to read if loaded or cached
    function bit known(logic [14:0] wa);
      int base;
      base = (wa % NSETS) * NWAYS;
      if (mem.exists(wa % NMEM)) return 1;
      for (int w = 0; w < NWAYS; w++)
        if (vld[base+w] && tag[base+w] == wa) return 1;
      return 0;
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;

  cache_scoreboard sb;
  int idle_pct = 0, stall_pct = 0;
  int hold_cycles = 0;
  logic [14:0] loaded[$];

  always #1 clk_i = ~clk_i;

  set_assoc_lru_writeback_cache_unit u_top (.*);

  // send one item, idling at random first; valid stays up until the next
  // item or a drain lowers it
  task automatic send_item(logic [1:0] cmd, bit wd, logic [15:0] addr,
                           logic [15:0] d);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {5'd0, d, addr, wd, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    // predictor runs in acceptance order
    sb.note_item(cmd, wd, addr, d);
    if (cmd == CMD_LOAD) loaded.push_back(addr[15:1]);
  endtask

  // receiver: random stalls, plus a long hold when requested
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0 || hold_cycles != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // mostly accesses to loaded words, in few sets to force evictions
  task automatic random_item();
    logic [15:0] addr, d;
    logic [1:0]  cmd;
    int          k;
    bit          wd;
    d = 16'($urandom);
    k = $urandom_range(99);
    if (k < 20 || loaded.size() == 0) begin
      cmd = CMD_LOAD;
      addr = (k < 10) ? 16'($urandom)
                      : 16'({$urandom_range(15), 3'b000} | $urandom_range(7));
    end else if (k < 23) begin
      cmd = 2'd3;
      addr = 16'($urandom);
    end else begin
      cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
      addr = 16'({loaded[$urandom_range(loaded.size() - 1)], 1'b0} | $urandom_range(1));
    end
    if (!sb.known(addr[15:1]) && (cmd == CMD_READ || cmd == CMD_WRITE)) cmd = CMD_LOAD;
    wd = 1'($urandom_range(1));
    // first load of a word writes it whole so no byte stays undefined
    if (cmd == CMD_LOAD && !sb.mem.exists(addr[15:1] % NMEM)) wd = 1;
    send_item(cmd, wd, addr, d);
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: loads at extremes, byte and word, then hits, misses, evictions
    send_item(CMD_LOAD, 1, 16'h0000, 16'hFFFF);
    send_item(CMD_LOAD, 1, 16'hFFFF, 16'hA55A);
    send_item(CMD_LOAD, 0, 16'h0009, 16'h0012);
    send_item(CMD_LOAD, 0, 16'h0008, 16'h0034);
    send_item(CMD_READ, 1, 16'h0000, 16'h0);
    send_item(CMD_READ, 1, 16'hFFFF, 16'h0);
    send_item(CMD_READ, 0, 16'h0009, 16'h0);
    send_item(CMD_READ, 0, 16'h0008, 16'h0);
    send_item(CMD_WRITE, 0, 16'h0001, 16'h00CD);
    send_item(CMD_WRITE, 1, 16'h0009, 16'hBEEF);
    send_item(2'd3, 1, 16'h1234, 16'hFFFF);
    send_item(CMD_LOAD, 1, 16'h0000, 16'h1111);
    send_item(CMD_READ, 1, 16'h0001, 16'h0);
    for (int i = 1; i <= 5; i++) send_item(CMD_LOAD, 1, 16'(i * 8), 16'(i));
    for (int i = 1; i <= 5; i++) send_item(CMD_WRITE, 0, 16'(i * 8 + 1), 16'hFF);
    send_item(CMD_READ, 1, 16'h0000, 16'h0);
    drain();
    // long receiver hold while the sender keeps offering
    hold_cycles = 60;
    for (int i = 0; i < 20; i++) random_item();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      for (int i = 0; i < 170; i++) random_item();
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("set_assoc_lru_writeback_cache_unit: match");
    else
      $display("set_assoc_lru_writeback_cache_unit: mismatch");
    $finish;
  end

  initial begin
    #200000;
    $display("set_assoc_lru_writeback_cache_unit: mismatch");
    $finish;
  end
endmodule

FILE: sim.f
hdl/salwc_pkg.sv
hdl/salwc_ctrl.sv
hdl/salwc_dp.sv
hdl/set_assoc_lru_writeback_cache_unit.sv
dv/set_assoc_lru_writeback_cache_unit_test.sv
